FILE: rtl/box_mean_3x3_stencil_macros.svh
// Assertion macros for the 3x3 box-mean stencil checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BOX_MEAN_3X3_STENCIL_MACROS_SVH
`define BOX_MEAN_3X3_STENCIL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box mean stencil check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box mean stencil check failed");

`endif

FILE: rtl/bms_pkg.sv
// Shared constants, types and register codes for the 3x3 box-mean stencil.
// Used by every module of the block and by its checker.
`default_nettype none

package bms_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int VALUE_W    = 16;
	localparam int ROW_W      = 16;
	localparam int COL_W      = 12;
	localparam int GW_W       = 13;
	localparam int GH_W       = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int COLSUM_W    = VALUE_W + 2;
	localparam int SUM_W       = VALUE_W + 4;
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_MUL   = 932068;
	localparam int PROD_W      = SUM_W + 20;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LEVEL_W    = FIFO_AW + 1;
	localparam int CRED_W     = LEVEL_W + 1;

	localparam int OUT_TDATA_W = 48;
	localparam int IN_TDATA_W  = 16;

	localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = GW_W'(4096);
	localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = GH_W'(4096);
	localparam logic [GW_W-1:0] MIN_WIDTH         = GW_W'(3);
	localparam logic [GW_W-1:0] MAX_WIDTH_W       = GW_W'(MAX_WIDTH);
	localparam logic [GH_W-1:0] MIN_HEIGHT        = GH_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [GW_W-1:0] width;
		logic [GH_W-1:0] height;
	} bms_geom_t;

	typedef struct packed {
		logic               interior;
		logic               border;
		logic [VALUE_W-1:0] mean;
		logic [VALUE_W-1:0] value;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
	} bms_item_t;

endpackage

`default_nettype wire

FILE: rtl/bms_front.sv
// Front part: position counters, line store, column-sum window and the
// divide-by-nine pipeline. Depends on bms_pkg.
`default_nettype none

module bms_front
	import bms_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bms_geom_t           geom,
	input  wire logic                in_valid,
	input  wire logic [VALUE_W-1:0]  in_value,
	input  wire logic                in_start,
	output logic                     in_ready,
	input  wire logic [LEVEL_W-1:0]  fifo_level,
	output logic                     push,
	output bms_item_t                push_item
);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] r_a;
	logic [GW_W-1:0]  c_a;
	logic [ROW_W-1:0] r_next;
	logic [GW_W-1:0]  c_next;
	logic             interior_a;
	logic             border_a;
	logic             accept;

	logic [2*VALUE_W-1:0] line_mem [MAX_WIDTH];

	logic                 v_s1, v_s2, v_s3;
	logic [2*VALUE_W-1:0] rd_s1;
	logic                 byp_s1;
	logic [VALUE_W-1:0]   byp_top_s1, byp_mid_s1;
	logic [VALUE_W-1:0]   val_s1, val_s2, val_s3;
	logic [ROW_W-1:0]     row_s1, row_s2, row_s3;
	logic [COL_W-1:0]     col_s1, col_s2, col_s3;
	logic                 int_s1, int_s2, int_s3;
	logic                 brd_s1, brd_s2, brd_s3;
	logic [VALUE_W-1:0]   top_s1, mid_s1;
	logic [COLSUM_W-1:0]  colsum_s1;
	logic [COLSUM_W-1:0]  cs_old_q, cs_mid_q;
	logic [SUM_W-1:0]     sum_s2;
	logic [PROD_W-1:0]    prod_s3;

	always_comb begin
		r_a = in_start ? '0 : row_q;
		c_a = in_start ? '0 : GW_W'(col_q);
		if (c_a >= geom.width) begin
			c_a = '0;
			r_a = r_a + ROW_W'(1);
		end
		if (r_a >= geom.height) begin
			r_a = '0;
		end
		r_next = r_a;
		c_next = c_a + GW_W'(1);
		if (c_next >= geom.width) begin
			c_next = '0;
			r_next = r_a + ROW_W'(1);
			if (r_next >= geom.height) begin
				r_next = '0;
			end
		end
		interior_a = (r_a >= ROW_W'(2)) && (c_a >= GW_W'(2));
		border_a = (r_a == '0) || (r_a == geom.height - GH_W'(1)) ||
			(c_a == '0) || (c_a == geom.width - GW_W'(1));
	end

	assign in_ready = (CRED_W'(fifo_level) + CRED_W'(v_s1) + CRED_W'(v_s2) + CRED_W'(v_s3))
		< CRED_W'(FIFO_DEPTH);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			cs_old_q <= '0;
			cs_mid_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept) begin
				row_q <= r_next;
				col_q <= c_next[COL_W-1:0];
			end
			if (v_s1) begin
				cs_old_q <= cs_mid_q;
				cs_mid_q <= colsum_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[c_a[ADDR_W-1:0]];
		end
		if (v_s1) begin
			line_mem[col_s1[ADDR_W-1:0]] <= {val_s1, mid_s1};
		end
	end

	always_comb begin
		top_s1 = byp_s1 ? byp_top_s1 : rd_s1[VALUE_W-1:0];
		mid_s1 = byp_s1 ? byp_mid_s1 : rd_s1[2*VALUE_W-1:VALUE_W];
		colsum_s1 = COLSUM_W'(top_s1) + COLSUM_W'(mid_s1) + COLSUM_W'(val_s1);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byp_s1 <= v_s1 && (c_a[COL_W-1:0] == col_s1);
			byp_top_s1 <= mid_s1;
			byp_mid_s1 <= val_s1;
			val_s1 <= in_value;
			row_s1 <= r_a;
			col_s1 <= c_a[COL_W-1:0];
			int_s1 <= interior_a;
			brd_s1 <= border_a;
		end
		sum_s2 <= SUM_W'(cs_old_q) + SUM_W'(cs_mid_q) + SUM_W'(colsum_s1) + SUM_W'(4);
		val_s2 <= val_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		int_s2 <= int_s1;
		brd_s2 <= brd_s1;
		prod_s3 <= PROD_W'(sum_s2) * PROD_W'(RECIP_MUL);
		val_s3 <= val_s2;
		row_s3 <= row_s2;
		col_s3 <= col_s2;
		int_s3 <= int_s2;
		brd_s3 <= brd_s2;
	end

	assign push = v_s3 && (int_s3 || brd_s3);

	always_comb begin
		push_item.interior = int_s3;
		push_item.border = brd_s3;
		push_item.mean = prod_s3[RECIP_SHIFT +: VALUE_W];
		push_item.value = val_s3;
		push_item.row = row_s3;
		push_item.col = col_s3;
	end

endmodule

`default_nettype wire

FILE: rtl/bms_fifo.sv
// Short item queue between the front and back parts of the stencil.
// Depends on bms_pkg; the front part keeps it from overflowing.
`default_nettype none

module bms_fifo
	import bms_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire bms_item_t    push_item,
	input  wire logic         pop,
	output logic              head_valid,
	output bms_item_t         head_item,
	output logic [LEVEL_W-1:0] level
);

	bms_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LEVEL_W-1:0]   level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10: level_q <= level_q + LEVEL_W'(1);
				2'b01: level_q <= level_q - LEVEL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_valid = (level_q != '0);
	assign head_item = mem_q[rd_ptr_q];
	assign level = level_q;

endmodule

`default_nettype wire

FILE: rtl/bms_back.sv
// Back part: splits each queued item into its interior and border beats
// and holds them in the output register. Depends on bms_pkg.
`default_nettype none

module bms_back
	import bms_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire bms_item_t              head_item,
	output logic                        pop,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output logic [OUT_TDATA_W-1:0]      m_data,
	output logic                        m_last
);

	logic                   phase_q;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                   m_last_q;
	logic                   load;
	logic                   send_int;
	logic                   beat_last;
	logic [OUT_TDATA_W-1:0] beat_data;

	always_comb begin
		load = !m_valid_q || m_ready;
		send_int = head_item.interior && !phase_q;
		beat_last = send_int ? !head_item.border : 1'b1;
		if (send_int) begin
			beat_data = {(OUT_TDATA_W - VALUE_W - ROW_W - COL_W)'(0),
				head_item.col - COL_W'(1), head_item.row - ROW_W'(1), head_item.mean};
		end else begin
			beat_data = {(OUT_TDATA_W - VALUE_W - ROW_W - COL_W)'(0),
				head_item.col, head_item.row, head_item.value};
		end
		pop = load && head_valid && beat_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			m_valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= !beat_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			m_data_q <= beat_data;
			m_last_q <= beat_last;
		end
	end

	assign m_valid = m_valid_q;
	assign m_data = m_data_q;
	assign m_last = m_last_q;

endmodule

`default_nettype wire

FILE: rtl/box_mean_3x3_stencil.sv
// 3x3 box-mean stencil, one time step over a raster-ordered grid.
// Grid cells enter on the slave stream, one per beat; s_axis_tuser marks the
// first cell of a grid and resets the row and column counters.
// Each interior cell becomes (sum of its 3x3 neighborhood + 4) / 9; border
// cells pass through unchanged. Every result beat carries its row and column.
// An interior result is sent when the cell below-right of it arrives, ahead of
// that cell's own border result; m_axis_tlast marks the last beat per input.
// Geometry is set through the write port (index 0 width, index 1 height);
// the user must write it only while the block is idle (not enforced). Width
// keeps its low 13 bits, clamped to 3..4096; height is raised to at least 3.
// Throughput is one input beat per cycle while s_axis_tready is high; the
// output register sends one beat per cycle while m_axis_tready is high. An
// accepted input passes line-store read, window sum, reciprocal multiply,
// then queue and output register. When the receiver stalls, the eight-entry
// item queue fills and s_axis_tready drops. Reset clears counters, window,
// queue and output valid; the unreset line store is used from grid row 2 on.
`default_nettype none

module box_mean_3x3_stencil
	import bms_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] cell_value
	input  wire logic                    s_axis_tuser,  // [0] frame_start
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0]       m_axis_tdata,  // [15:0] out_value, [31:16] out_row,
	                                                    // [43:32] out_col, [47:44] zero
	output logic                         m_axis_tlast,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	logic [GW_W-1:0]    grid_width_q;
	logic [GH_W-1:0]    grid_height_q;
	bms_geom_t          geom;
	logic               push;
	bms_item_t          push_item;
	logic               pop;
	logic               head_valid;
	bms_item_t          head_item;
	logic [LEVEL_W-1:0] fifo_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RESET;
			grid_height_q <= GRID_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH: grid_width_q <= cfg_data[GW_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[GH_W-1:0];
				default: grid_width_q <= grid_width_q;
			endcase
		end
	end

	always_comb begin
		if (grid_width_q < MIN_WIDTH) begin
			geom.width = MIN_WIDTH;
		end else if (grid_width_q > MAX_WIDTH_W) begin
			geom.width = MAX_WIDTH_W;
		end else begin
			geom.width = grid_width_q;
		end
		geom.height = (grid_height_q < MIN_HEIGHT) ? MIN_HEIGHT : grid_height_q;
	end

	bms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.in_valid   (s_axis_tvalid),
		.in_value   (s_axis_tdata[VALUE_W-1:0]),
		.in_start   (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.fifo_level (fifo_level),
		.push       (push),
		.push_item  (push_item)
	);

	bms_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.level      (fifo_level)
	);

	bms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_axis_tdata),
		.m_last     (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: rtl/bms_checker.sv
// Port-level checker for the 3x3 box-mean stencil, bound to the top level.
// Depends on bms_pkg and the stencil assertion macros header.
`default_nettype none
`include "box_mean_3x3_stencil_macros.svh"

module bms_checker
	import bms_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tlast
);

	`BMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	`BMS_ASSERT_NOW(a_quiet_after_reset, $rose(arst_n), !m_axis_tvalid)
	`BMS_ASSERT_NEXT(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
	`BMS_ASSERT_NOW(a_interior_pos, m_axis_tvalid && !m_axis_tlast, (m_axis_tdata[31:16] != '0) && (m_axis_tdata[43:32] != '0))

endmodule

bind box_mean_3x3_stencil bms_checker u_bms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
